[rtl/sstf_pkg.sv]
// shared types, codes and constants for the disk request scheduler
`timescale 1ns / 1ps
`default_nettype none

package sstf_pkg;

   // default queue size and number of priority levels
   localparam int DEF_QUEUE_DEPTH = 8;
   localparam int LEVELS          = 4;

   // reset value of the seek overhead register
   localparam logic [15:0] SEEK_OVERHEAD_RESET = 16'd10;

   // operation codes
   localparam logic OP_ENQUEUE  = 1'b0;
   localparam logic OP_DISPATCH = 1'b1;

   // policy codes
   localparam logic POLICY_FCFS = 1'b0;
   localparam logic POLICY_SSTF = 1'b1;

   // result status codes
   localparam logic [1:0] ST_ENQUEUED   = 2'd0;
   localparam logic [1:0] ST_FULL       = 2'd1;
   localparam logic [1:0] ST_DISPATCHED = 2'd2;
   localparam logic [1:0] ST_EMPTY      = 2'd3;

   // configuration register indexes
   localparam int          CSR_INDEX_W       = 1;
   localparam int          CSR_DATA_W        = 16;
   localparam logic [CSR_INDEX_W-1:0] CSR_POLICY        = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SEEK_OVERHEAD = 1'b1;

   typedef struct packed {
      logic        operation;
      logic [7:0]  request_tag;
      logic [31:0] block_number;
      logic        is_write;
      logic [1:0]  priority_level;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [7:0]  granted_tag;
      logic [31:0] granted_block;
      logic        granted_write;
      logic [1:0]  granted_level;
      logic [31:0] seek_distance;
      logic [32:0] service_cost;
   } rsp_type;

   // one pending request
   typedef struct packed {
      logic [7:0]  tag;
      logic [31:0] block;
      logic        wr;
      logic [1:0]  level;
   } entry_type;

   // commands from the controller to the datapath
   typedef struct packed {
      logic enq;         // store request or report full
      logic disp_empty;  // report empty queue
      logic scan_start;  // clear running best and scan index
      logic scan_step;   // examine one entry
      logic commit;      // remove best entry, move head, post result
   } cmd_type;

   // status from the datapath to the controller
   typedef struct packed {
      logic count_zero;
      logic scan_last;
   } stat_type;

endpackage

`default_nettype wire

[rtl/sstf_ctrl.sv]
// controller state machine for the disk request scheduler
`timescale 1ns / 1ps
`default_nettype none

module sstf_ctrl (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   input  wire logic               operation,
   input  wire sstf_pkg::stat_type stat,
   output logic                    busy,
   output sstf_pkg::cmd_type       cmd
);

   localparam logic [1:0] S_IDLE   = 2'd0;
   localparam logic [1:0] S_SCAN   = 2'd1;
   localparam logic [1:0] S_COMMIT = 2'd2;

   logic [1:0] state_ff;
   logic [1:0] state_in;

   assign busy = (state_ff != S_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               if (operation == sstf_pkg::OP_ENQUEUE) begin
                  cmd.enq = 1'b1;
               end else if (stat.count_zero) begin
                  cmd.disp_empty = 1'b1;
               end else begin
                  cmd.scan_start = 1'b1;
                  state_in       = S_SCAN;
               end
            end
         end
         S_SCAN: begin
            cmd.scan_step = 1'b1;
            if (stat.scan_last) begin
               state_in = S_COMMIT;
            end
         end
         S_COMMIT: begin
            cmd.commit = 1'b1;
            state_in   = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

[rtl/sstf_dp.sv]
// datapath: pending queue, best-entry scan, compaction, result register
`timescale 1ns / 1ps
`default_nettype none

module sstf_dp #(
   parameter int QUEUE_DEPTH = sstf_pkg::DEF_QUEUE_DEPTH
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire sstf_pkg::req_type                    req_data,
   input  wire sstf_pkg::cmd_type                    cmd,
   input  wire logic                                 csr_valid,
   input  wire logic [sstf_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  wire logic [sstf_pkg::CSR_DATA_W-1:0]      csr_wdata,
   output logic                                      csr_ready,
   output sstf_pkg::stat_type                        stat,
   output logic                                      rsp_valid,
   output sstf_pkg::rsp_type                         rsp_data
);

   localparam int IDX_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

   sstf_pkg::entry_type entry_ff [QUEUE_DEPTH];

   logic [CNT_W-1:0] count_ff,  count_in;
   logic [31:0]      head_ff,   head_in;
   logic             policy_ff, policy_in;
   logic [15:0]      ovh_ff,    ovh_in;
   logic [IDX_W-1:0] idx_ff,    idx_in;
   logic [IDX_W-1:0] pick_ff,   pick_in;
   logic             best_valid_ff, best_valid_in;
   sstf_pkg::entry_type best_ff, best_in;
   logic [31:0]      best_dist_ff, best_dist_in;
   logic             rsp_valid_ff, rsp_valid_in;
   sstf_pkg::rsp_type rsp_ff, rsp_in;

   sstf_pkg::entry_type cur;
   sstf_pkg::entry_type new_entry;
   logic [31:0] cur_dist;
   logic        take;
   logic        count_full;

   assign csr_ready  = 1'b1;
   assign count_full = (count_ff == CNT_FULL);
   assign stat.count_zero = (count_ff == '0);
   assign stat.scan_last  = (policy_ff == sstf_pkg::POLICY_FCFS) ||
                            ((CNT_W'(idx_ff) + CNT_ONE) == count_ff);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // entry under examination and its distance from the head
   assign cur      = entry_ff[idx_ff];
   assign cur_dist = (head_ff > cur.block) ? (head_ff - cur.block) : (cur.block - head_ff);
   // strict compare keeps the earliest arrival on ties
   assign take = !best_valid_ff ||
                 ({cur.level, cur_dist} < {best_ff.level, best_dist_ff});

   always_comb begin
      new_entry.tag   = req_data.request_tag;
      new_entry.block = req_data.block_number;
      new_entry.wr    = req_data.is_write;
      new_entry.level = req_data.priority_level;
      // levels above the top one saturate
      if (int'(req_data.priority_level) > sstf_pkg::LEVELS - 1) begin
         new_entry.level = 2'(sstf_pkg::LEVELS - 1);
      end
   end

   always_comb begin
      count_in      = count_ff;
      head_in       = head_ff;
      policy_in     = policy_ff;
      ovh_in        = ovh_ff;
      idx_in        = idx_ff;
      pick_in       = pick_ff;
      best_valid_in = best_valid_ff;
      best_in       = best_ff;
      best_dist_in  = best_dist_ff;
      rsp_valid_in  = 1'b0;
      rsp_in        = rsp_ff;

      if (csr_valid) begin
         case (csr_index)
            sstf_pkg::CSR_POLICY:        policy_in = csr_wdata[0];
            sstf_pkg::CSR_SEEK_OVERHEAD: ovh_in    = csr_wdata;
            default: ;
         endcase
      end

      if (cmd.enq) begin
         rsp_valid_in = 1'b1;
         rsp_in       = '0;
         if (count_full) begin
            rsp_in.status = sstf_pkg::ST_FULL;
         end else begin
            rsp_in.status = sstf_pkg::ST_ENQUEUED;
            count_in      = count_ff + CNT_ONE;
         end
      end

      if (cmd.disp_empty) begin
         rsp_valid_in  = 1'b1;
         rsp_in        = '0;
         rsp_in.status = sstf_pkg::ST_EMPTY;
      end

      if (cmd.scan_start) begin
         idx_in        = '0;
         best_valid_in = 1'b0;
      end

      if (cmd.scan_step) begin
         idx_in        = idx_ff + IDX_W'(1);
         best_valid_in = 1'b1;
         if (take) begin
            best_in      = cur;
            best_dist_in = cur_dist;
            pick_in      = idx_ff;
         end
      end

      if (cmd.commit) begin
         count_in             = count_ff - CNT_ONE;
         head_in              = best_ff.block;
         rsp_valid_in         = 1'b1;
         rsp_in.status        = sstf_pkg::ST_DISPATCHED;
         rsp_in.granted_tag   = best_ff.tag;
         rsp_in.granted_block = best_ff.block;
         rsp_in.granted_write = best_ff.wr;
         rsp_in.granted_level = best_ff.level;
         rsp_in.seek_distance = best_dist_ff;
         rsp_in.service_cost  = {1'b0, best_dist_ff} + {17'b0, ovh_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff      <= '0;
         head_ff       <= '0;
         policy_ff     <= sstf_pkg::POLICY_FCFS;
         ovh_ff        <= sstf_pkg::SEEK_OVERHEAD_RESET;
         best_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         count_ff      <= count_in;
         head_ff       <= head_in;
         policy_ff     <= policy_in;
         ovh_ff        <= ovh_in;
         best_valid_ff <= best_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff       <= idx_in;
      pick_ff      <= pick_in;
      best_ff      <= best_in;
      best_dist_ff <= best_dist_in;
      rsp_ff       <= rsp_in;
   end

   // queue storage: append at the tail, close the gap on removal
   always_ff @(posedge clock) begin
      for (int i = 0; i < QUEUE_DEPTH - 1; i++) begin
         if (cmd.enq && !count_full && (count_ff == CNT_W'(i))) begin
            entry_ff[i] <= new_entry;
         end else if (cmd.commit && (int'(pick_ff) <= i)) begin
            entry_ff[i] <= entry_ff[i+1];
         end
      end
      if (cmd.enq && !count_full && (count_ff == CNT_W'(QUEUE_DEPTH - 1))) begin
         entry_ff[QUEUE_DEPTH-1] <= new_entry;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_FULL)
      else $error("pending count exceeds queue depth");

   a_commit_nonempty: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |-> (count_ff != '0) && best_valid_ff)
      else $error("commit without a selected entry");

   a_commit_result: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |=> rsp_valid_ff && (rsp_ff.status == sstf_pkg::ST_DISPATCHED))
      else $error("commit did not post a dispatch result");

   a_full_holds: assert property (@(posedge clock) disable iff (reset)
      cmd.enq && count_full |=> (count_ff == $past(count_ff)) &&
                                (rsp_ff.status == sstf_pkg::ST_FULL))
      else $error("rejected enqueue changed the queue");

endmodule

`default_nettype wire

[rtl/priority_sstf_disk_request_scheduler_core.sv]
// top level of the priority shortest-seek disk request scheduler
`timescale 1ns / 1ps
`default_nettype none

// pending disk-request queue with first-come or priority/shortest-seek dispatch
// request channel: an item is taken on a clock edge with start high and busy low;
//   req_data.operation selects enqueue or dispatch
// result channel: every item yields one beat on rsp_data, flagged by rsp_valid
//   for exactly one cycle; the receiver cannot stall it
// csr channel: csr_index 0 is the policy, 1 the seek overhead; csr_ready is
//   always high; user must write only while the block is idle (not enforced)
// sequencing and throughput:
//   enqueue or dispatch on an empty queue: result the cycle after accept,
//     busy stays low, so one such item per cycle
//   dispatch: a scan over every pending entry under priority/shortest-seek (one
//     entry per cycle through a single distance compare), a scan of the oldest
//     entry alone under first-come, then a commit; the result follows the commit
//     and busy stays high in between, so no new item is taken meanwhile
// reset: queue empty, head at block 0, first-come policy, seek overhead 10;
//   no clearing pass, stored entries are only read below the fill count

module priority_sstf_disk_request_scheduler_core #(
   parameter int QUEUE_DEPTH = sstf_pkg::DEF_QUEUE_DEPTH
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   // request channel
   input  wire logic                              start,
   output logic                                   busy,
   input  wire sstf_pkg::req_type                 req_data,
   // result channel
   output logic                                   rsp_valid,
   output sstf_pkg::rsp_type                      rsp_data,
   // configuration channel
   input  wire logic                              csr_valid,
   output logic                                   csr_ready,
   input  wire logic [sstf_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  wire logic [sstf_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   sstf_pkg::cmd_type  cmd;   // controller -> datapath
   sstf_pkg::stat_type stat;  // datapath -> controller

   // sequencing: accept, scan, commit
   sstf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .operation (req_data.operation),
      .stat      (stat),
      .busy      (busy),
      .cmd       (cmd)
   );

   // queue storage, selection and result register
   sstf_dp #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .csr_ready (csr_ready),
      .stat      (stat),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire
